// ===== design/car_pkg.sv =====
// shared types and constants for the cubic audio resampler
package car_pkg;

	// fraction bits of the interpolation weight inside the lane arithmetic
	localparam int POLY_BITS = 16;

	// pipeline depth of one interpolation lane
	localparam int LANE_STAGES = 8;

	// configuration register widths and reset values
	localparam int STEP_BITS = 20;
	localparam int CHAN_BITS = 2;
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 20'h10000;
	localparam logic [CHAN_BITS-1:0] CHAN_RESET = 2'd2;
	localparam logic [CHAN_BITS-1:0] CHAN_STEREO = 2'd2;

	// window shifts that close a stream on its final frame
	localparam logic [1:0] TAIL_STEPS = 2'd2;

	// register index taken from the word address
	typedef enum logic {
		REG_PHASE_STEP    = 1'b0,
		REG_CHANNEL_COUNT = 1'b1
	} reg_idx_t;

	// window update command from the sequencer to every lane
	typedef struct packed {
		logic load;
		logic push;
		logic repl;
	} win_cmd_t;

	// sideband that travels beside the lane pipeline
	typedef struct packed {
		logic is_done;
		logic fin;
		logic stereo;
	} side_t;

endpackage

// ===== design/car_lane.sv =====
// one interpolation lane: four-frame window and pipelined catmull-rom evaluation
module car_lane import car_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          adv,
	input  win_cmd_t                      cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [POLY_BITS-1:0]          fr,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int CW = SAMPLE_BITS + 4;
	localparam int AW = SAMPLE_BITS + 22;
	localparam int PW = AW + POLY_BITS + 1;
	localparam logic signed [AW-1:0] ROUND_C = AW'(64'sd1 <<< POLY_BITS);
	localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

	logic signed [SAMPLE_BITS-1:0] win_q [4];

	logic signed [CW-1:0] y0, y1, y2, y3;
	logic signed [CW-1:0] c0_n, c1_n, c2_n, c3_n;
	logic signed [PW-1:0] m2, m4, m6;
	logic signed [AW-1:0] acc3_n, acc5_n, acc7_n, rnd;

	logic [POLY_BITS-1:0] fr_s1, fr_s2, fr_s3, fr_s4, fr_s5;
	logic signed [CW-1:0] c0_s1, c0_s2, c0_s3, c0_s4, c0_s5, c0_s6;
	logic signed [CW-1:0] c1_s1, c1_s2, c1_s3, c1_s4;
	logic signed [CW-1:0] c2_s1, c2_s2;
	logic signed [CW-1:0] c3_s1;
	logic signed [AW-1:0] prod_s2, acc_s3, prod_s4, acc_s5, prod_s6, acc_s7;
	logic signed [SAMPLE_BITS-1:0] res_s8;

	// window: fill on first frame, shift in new or repeated last frame
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[0] <= sample_in;
			win_q[1] <= sample_in;
			win_q[2] <= sample_in;
			win_q[3] <= sample_in;
		end else if (cmd.push || cmd.repl) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= cmd.push ? sample_in : win_q[3];
		end
	end

	// polynomial coefficients and horner steps
	always_comb begin
		y0 = CW'(win_q[0]);
		y1 = CW'(win_q[1]);
		y2 = CW'(win_q[2]);
		y3 = CW'(win_q[3]);
		c0_n = y1 <<< 1;
		c1_n = y2 - y0;
		c2_n = (y0 <<< 1) - ((y1 <<< 2) + y1) + (y2 <<< 2) - y3;
		c3_n = -y0 + ((y1 <<< 1) + y1) - ((y2 <<< 1) + y2) + y3;
		m2 = PW'($signed({1'b0, fr_s1})) * PW'(c3_s1);
		acc3_n = (AW'(c2_s2) <<< POLY_BITS) + prod_s2;
		m4 = PW'($signed({1'b0, fr_s3})) * PW'(acc_s3);
		acc5_n = (AW'(c1_s4) <<< POLY_BITS) + prod_s4;
		m6 = PW'($signed({1'b0, fr_s5})) * PW'(acc_s5);
		acc7_n = (AW'(c0_s6) <<< POLY_BITS) + prod_s6;
		rnd = (acc_s7 + ROUND_C) >>> (POLY_BITS + 1);
	end

	// eight-stage evaluation pipeline, stalled as a whole
	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s1 <= fr;
			c0_s1 <= c0_n;
			c1_s1 <= c1_n;
			c2_s1 <= c2_n;
			c3_s1 <= c3_n;

			fr_s2 <= fr_s1;
			c0_s2 <= c0_s1;
			c1_s2 <= c1_s1;
			c2_s2 <= c2_s1;
			prod_s2 <= AW'(m2);

			fr_s3 <= fr_s2;
			c0_s3 <= c0_s2;
			c1_s3 <= c1_s2;
			acc_s3 <= acc3_n;

			fr_s4 <= fr_s3;
			c0_s4 <= c0_s3;
			c1_s4 <= c1_s3;
			prod_s4 <= AW'(m4 >>> POLY_BITS);

			fr_s5 <= fr_s4;
			c0_s5 <= c0_s4;
			acc_s5 <= acc5_n;

			c0_s6 <= c0_s5;
			prod_s6 <= AW'(m6 >>> POLY_BITS);

			acc_s7 <= acc7_n;

			if (rnd > SAT_HI) begin
				res_s8 <= SAT_HI[SAMPLE_BITS-1:0];
			end else if (rnd < SAT_LO) begin
				res_s8 <= SAT_LO[SAMPLE_BITS-1:0];
			end else begin
				res_s8 <= rnd[SAMPLE_BITS-1:0];
			end
		end
	end

	assign result = res_s8;

endmodule

// ===== design/car_merge.sv =====
// merge stage: joins lane results, holds back one result to mark run and stream ends
module car_merge import car_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  side_t                         side,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          adv,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_result,
	output logic signed [SAMPLE_BITS-1:0] right_result,
	output logic                          run_end,
	output logic                          stream_end
);

	logic                          out_valid_q;
	logic                          pend_valid_q;
	logic signed [SAMPLE_BITS-1:0] pend_left_q, pend_right_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;
	logic                          run_end_q, stream_end_q;
	logic                          push_res, push_done, emit;

	// pipeline moves when the output register is free or being taken
	always_comb begin
		adv = !out_valid_q || out_ready;
		push_res = adv && in_vld && !side.is_done;
		push_done = adv && in_vld && side.is_done;
		emit = (push_res || push_done) && pend_valid_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= emit;
			end
			if (push_res) begin
				pend_valid_q <= 1'b1;
			end else if (push_done) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// held result and output transaction payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_left_q <= pend_left_q;
			out_right_q <= pend_right_q;
			run_end_q <= push_done;
			stream_end_q <= push_done && side.fin;
		end
		if (push_res) begin
			pend_left_q <= left_in;
			pend_right_q <= side.stereo ? right_in : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign left_result = out_left_q;
	assign right_result = out_right_q;
	assign run_end = run_end_q;
	assign stream_end = stream_end_q;

endmodule

// ===== design/cubic_audio_resampler_unit.sv =====
// top level of the catmull-rom cubic audio resampler
//
// Takes one frame (left, right, final marker) per input transaction and gives every
// interpolated output frame whose position falls inside the stream, one output
// transaction per result. A small sequencer walks the read position: it accepts a frame,
// issues one result per read position inside the window step, makes the end-of-stream
// window shifts (two on a final frame) and then closes the frame; issuing and closing
// wait while the output is stalled. A frame yields at most 16 results per window step
// at the smallest phase step. The sequencer issues at most one result per cycle into
// the lanes, and the next frame is accepted once the current one is closed. Each
// channel has its own lane, an eight-stage pipeline that evaluates the cubic with one
// multiplier per Horner step; the merge stage after it holds one result back to flag
// the last result of a frame. phase_step is clamped to the range 1/16 to 8.0; with
// channel_count below two the right channel reads as zero.
module cubic_audio_resampler_unit import car_pkg::*; #(
	parameter int LANES = 2,
	parameter int SAMPLE_BITS = 16,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input frames
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          final_frame,
	// output frames
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_result,
	output logic signed [SAMPLE_BITS-1:0] right_result,
	output logic                          run_end,
	output logic                          stream_end,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_BITS-1:0]         paddr,
	input  logic [PDATA_BITS-1:0]         pwdata,
	output logic [PDATA_BITS-1:0]         prdata,
	output logic                          pready
);

	localparam int POS_W = PHASE_FRAC_BITS + 4;
	localparam int SW = (STEP_BITS > POS_W) ? STEP_BITS : POS_W;
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << PHASE_FRAC_BITS;
	localparam logic [POS_W-1:0] POS_TWO = POS_ONE << 1;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(9 * (64'd1 << PHASE_FRAC_BITS));
	localparam logic [SW-1:0] STEP_LO = SW'(64'd1 << PHASE_FRAC_BITS) >> 4;
	localparam logic [SW-1:0] STEP_HI = SW'(64'd1 << PHASE_FRAC_BITS) << 3;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t               state_q;
	logic [POS_W-1:0]     pos_q;
	logic [1:0]           tail_q;
	logic                 fin_q;
	logic                 stereo_q;
	logic                 first_q;

	logic [STEP_BITS-1:0] phase_step_q;
	logic [CHAN_BITS-1:0] channel_count_q;

	logic                 adv;
	logic                 accept;
	logic                 stereo_now;
	logic                 run_more;
	logic                 issue_res;
	logic                 issue_done;
	logic                 tail_step;
	logic [SW-1:0]        step_ext;
	logic [SW-1:0]        step_clamped;
	logic [POS_W-1:0]     step_eff;
	logic [POLY_BITS-1:0] fr;
	win_cmd_t             win_cmd;
	side_t                issue_side;

	logic [LANE_STAGES-1:0] vld_q;
	side_t                  side_q [LANE_STAGES];

	logic signed [SAMPLE_BITS-1:0] lane_in  [LANES];
	logic signed [SAMPLE_BITS-1:0] lane_out [LANES];
	logic signed [SAMPLE_BITS-1:0] right_lane;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= STEP_RESET;
			channel_count_q <= CHAN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_PHASE_STEP: begin
					phase_step_q <= pwdata[STEP_BITS-1:0];
				end
				REG_CHANNEL_COUNT: begin
					channel_count_q <= pwdata[CHAN_BITS-1:0];
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_PHASE_STEP: begin
				prdata = PDATA_BITS'(phase_step_q);
			end
			REG_CHANNEL_COUNT: begin
				prdata = PDATA_BITS'(channel_count_q);
			end
		endcase
	end

	assign pready = 1'b1;

	// step clamp and fraction for the lanes
	always_comb begin
		step_ext = SW'(phase_step_q);
		if (step_ext < STEP_LO) begin
			step_clamped = STEP_LO;
		end else if (step_ext > STEP_HI) begin
			step_clamped = STEP_HI;
		end else begin
			step_clamped = step_ext;
		end
		step_eff = step_clamped[POS_W-1:0];
	end

	if (PHASE_FRAC_BITS >= POLY_BITS) begin : g_fr_cut
		assign fr = pos_q[PHASE_FRAC_BITS-1 -: POLY_BITS];
	end else begin : g_fr_pad
		assign fr = {pos_q[PHASE_FRAC_BITS-1:0], {(POLY_BITS - PHASE_FRAC_BITS){1'b0}}};
	end

	// sequencer decisions
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		accept = in_valid && in_ready;
		stereo_now = (LANES >= 2) && (channel_count_q >= CHAN_STEREO);
		run_more = (pos_q[POS_W-1:PHASE_FRAC_BITS] == '0);
		issue_res = (state_q == ST_RUN) && run_more && adv;
		tail_step = (state_q == ST_RUN) && !run_more && (tail_q != 2'd0);
		issue_done = (state_q == ST_RUN) && !run_more && (tail_q == 2'd0) && adv;
		win_cmd.load = accept && !first_q;
		win_cmd.push = accept && first_q;
		win_cmd.repl = tail_step;
		issue_side.is_done = issue_done;
		issue_side.fin = fin_q;
		issue_side.stereo = stereo_q;
	end

	// sequencer state and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			tail_q <= 2'd0;
			fin_q <= 1'b0;
			stereo_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						fin_q <= final_frame;
						tail_q <= final_frame ? TAIL_STEPS : 2'd0;
						stereo_q <= stereo_now;
						first_q <= 1'b1;
						pos_q <= first_q ? (pos_q - POS_ONE) : POS_TWO;
					end
				end
				ST_RUN: begin
					if (run_more) begin
						if (adv) begin
							pos_q <= pos_q + step_eff;
						end
					end else if (tail_q != 2'd0) begin
						tail_q <= tail_q - 2'd1;
						pos_q <= pos_q - POS_ONE;
					end else if (adv) begin
						state_q <= ST_IDLE;
						if (fin_q) begin
							first_q <= 1'b0;
							pos_q <= '0;
						end
					end
				end
			endcase
		end
	end

	// sideband pipeline beside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LANE_STAGES-2:0], issue_res || issue_done};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= issue_side;
			for (int i = 1; i < LANE_STAGES; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// lane inputs
	assign lane_in[0] = left_sample;
	if (LANES >= 2) begin : g_right_in
		assign lane_in[1] = stereo_now ? right_sample : '0;
		assign right_lane = lane_out[1];
	end else begin : g_mono
		assign right_lane = '0;
	end

	// one interpolation lane per channel
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		car_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk      (clk),
			.adv      (adv),
			.cmd      (win_cmd),
			.sample_in(lane_in[g]),
			.fr       (fr),
			.result   (lane_out[g])
		);
	end

	// merge lanes into output transactions
	car_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_q[LANE_STAGES-1]),
		.side        (side_q[LANE_STAGES-1]),
		.left_in     (lane_out[0]),
		.right_in    (right_lane),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_result (left_result),
		.right_result(right_result),
		.run_end     (run_end),
		.stream_end  (stream_end)
	);

`ifndef SYNTHESIS
	// read position stays below one window step plus the largest phase step
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_LIMIT)
		else $error("read position out of range");

	// end-of-stream shifts only happen on a final frame
	a_tail_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q != 2'd0) |-> fin_q)
		else $error("tail shift without final frame");

	// a frame is closed only after its tail shifts are done
	a_idle_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tail_q == 2'd0))
		else $error("frame closed with tail shifts pending");

	// stream end always falls on the last result of a frame
	a_stream_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stream_end) |-> run_end)
		else $error("stream end without run end");
`endif

endmodule
